@@ rtl/core/vswa_pkg.sv @@
// vswa_pkg: shared constants and types for the vector sliding window averager
// no dependencies
package vswa_pkg;
    localparam int MAX_VECTOR_LENGTH = 64;
    localparam int MAX_WINDOW        = 64;
    localparam int SAMPLE_BITS       = 16;
    localparam int CFG_BITS          = 7;
    localparam logic CFG_VECTOR_LENGTH = 1'b0;
    localparam logic CFG_WINDOW_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        t_st_idle,
        t_st_read,
        t_st_div,
        t_st_out
    } t_state;
endpackage

@@ rtl/core/vswa_if.sv @@
// vswa_if: valid/ready channel carrying a generic payload
// depends on nothing
interface vswa_if #(parameter int W = 32) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/vswa_ram.sv @@
// vswa_ram: generic single port ram with registered read
// no dependencies
module vswa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/core/vector_sliding_window_average.sv @@
// vector_sliding_window_average: top level, windowed complex averager
// depends on vswa_pkg, vswa_if, vswa_ram
//
// channel | dir | payload
// s_in    | in  | {sample_re, sample_im}
// m_out   | out | {avg_re, avg_im, vector_end}
//
// steps for one word with the output free: history and sum reads start at the
// accepting edge, then update and write-back, a restoring divider one quotient bit
// a cycle, result load, back to idle
// reset is synchronous; sums live behind per-entry valid bits so no clearing pass
// a finished result waits in the output register while the next word is taken;
// the next result holds in the divider until that register frees, input stalled
module vector_sliding_window_average #(
    parameter int MAX_VECTOR_LENGTH = vswa_pkg::MAX_VECTOR_LENGTH,
    parameter int MAX_WINDOW        = vswa_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS       = vswa_pkg::SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic [vswa_pkg::CFG_BITS-1:0] i_cfg_data,
    vswa_if.sink   s_in,
    vswa_if.source m_out
);
    localparam int PW   = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
    localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = SAMPLE_BITS + CW;
    localparam int HD   = MAX_VECTOR_LENGTH * MAX_WINDOW;
    localparam int AW   = $clog2(HD);
    localparam int QW   = $clog2(SUMW + 1);
    localparam int CB   = vswa_pkg::CFG_BITS;

    // config registers and clamped lengths
    logic [CB-1:0] r_vlen, r_wlen;
    logic [PW:0]   vl;
    logic [CW-1:0] wl;
    always_comb begin
        if (r_vlen == '0) vl = (PW+1)'(1);
        else if (32'(r_vlen) > MAX_VECTOR_LENGTH) vl = (PW+1)'(MAX_VECTOR_LENGTH);
        else vl = (PW+1)'(r_vlen);
        if (r_wlen == '0) wl = CW'(1);
        else if (32'(r_wlen) > MAX_WINDOW) wl = CW'(MAX_WINDOW);
        else wl = CW'(r_wlen);
    end

    vswa_pkg::t_state r_state, n_state;
    logic [PW-1:0]  r_pos;
    logic [CW-1:0]  r_seen;
    logic [SW-1:0]  r_slot;
    logic [MAX_VECTOR_LENGTH-1:0] r_sum_ok;
    logic signed [SAMPLE_BITS-1:0] r_re, r_im;
    logic           r_full, r_last;
    logic [CW-1:0]  r_n;
    logic [QW-1:0]  r_cnt;
    logic           r_neg_re, r_neg_im;
    logic [SUMW-1:0] r_q_re, r_q_im, r_rm_re, r_rm_im;
    logic [2*SAMPLE_BITS:0] r_out;
    logic           r_ovalid;

    wire acc_in  = s_in.valid && s_in.ready;
    wire acc_out = m_out.valid && m_out.ready;
    // quotient moves into the output register once it is empty or leaving
    wire load_out = (r_state == vswa_pkg::t_st_out) && (!r_ovalid || acc_out);
    assign s_in.ready  = (r_state == vswa_pkg::t_st_idle);
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;

    // history memory: one entry per position and slot
    logic [AW-1:0] h_addr;
    logic [2*SAMPLE_BITS-1:0] h_rdata;
    logic h_we;
    assign h_addr = AW'(r_pos) * AW'(MAX_WINDOW) + AW'(r_slot);
    assign h_we   = (r_state == vswa_pkg::t_st_read);
    vswa_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(HD)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_addr(h_addr),
        .i_wdata({r_re, r_im}), .o_rdata(h_rdata));

    // sum memory, real and imaginary side by side
    logic [2*SUMW-1:0] s_rdata, s_wdata;
    logic signed [SUMW-1:0] sr, si, nr, ni;
    vswa_ram #(.WIDTH(2*SUMW), .DEPTH(MAX_VECTOR_LENGTH)) u_sum (
        .i_clk(i_clk), .i_we(h_we), .i_addr(r_pos),
        .i_wdata(s_wdata), .o_rdata(s_rdata));

    always_comb begin
        // unwritten sums read as zero through the valid bits
        sr = r_sum_ok[r_pos] ? $signed(s_rdata[2*SUMW-1:SUMW]) : '0;
        si = r_sum_ok[r_pos] ? $signed(s_rdata[SUMW-1:0]) : '0;
        nr = sr + SUMW'(r_re);
        ni = si + SUMW'(r_im);
        if (r_full) begin
            nr = nr - SUMW'($signed(h_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
            ni = ni - SUMW'($signed(h_rdata[SAMPLE_BITS-1:0]));
        end
        s_wdata = {nr, ni};
    end

    // restoring divide step on magnitudes
    logic [SUMW:0] tr_re, tr_im, pr_re, pr_im;
    always_comb begin
        pr_re = {r_rm_re, r_q_re[SUMW-1]};
        pr_im = {r_rm_im, r_q_im[SUMW-1]};
        tr_re = pr_re - (SUMW+1)'(r_n);
        tr_im = pr_im - (SUMW+1)'(r_n);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vswa_pkg::t_st_idle: if (acc_in) n_state = vswa_pkg::t_st_read;
            vswa_pkg::t_st_read: n_state = vswa_pkg::t_st_div;
            vswa_pkg::t_st_div:  if (r_cnt == QW'(SUMW)) n_state = vswa_pkg::t_st_out;
            vswa_pkg::t_st_out:  if (load_out) n_state = vswa_pkg::t_st_idle;
            default:             n_state = vswa_pkg::t_st_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vswa_pkg::t_st_idle;
            r_vlen   <= CB'(1);
            r_wlen   <= CB'(8);
            r_pos    <= '0;
            r_seen   <= '0;
            r_slot   <= '0;
            r_sum_ok <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) r_ovalid <= 1'b1;
            else if (acc_out) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == vswa_pkg::CFG_VECTOR_LENGTH) r_vlen <= i_cfg_data;
                else r_wlen <= i_cfg_data;
                r_pos    <= '0;
                r_seen   <= '0;
                r_slot   <= '0;
                r_sum_ok <= '0;
            end else if (r_state == vswa_pkg::t_st_read) begin
                r_sum_ok[r_pos] <= 1'b1;
                if (r_last) begin
                    r_pos <= '0;
                    if (r_seen < wl) r_seen <= r_seen + CW'(1);
                    r_slot <= (CW'(r_slot) + CW'(1) >= wl) ? '0 : r_slot + SW'(1);
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            vswa_pkg::t_st_idle: begin
                r_re   <= s_in.data[2*SAMPLE_BITS-1:SAMPLE_BITS];
                r_im   <= s_in.data[SAMPLE_BITS-1:0];
                r_full <= (r_seen >= wl);
                r_last <= ((PW+1)'(r_pos) == vl - (PW+1)'(1));
                r_n    <= (r_seen >= wl) ? wl : r_seen + CW'(1);
            end
            vswa_pkg::t_st_read: begin
                r_neg_re <= nr[SUMW-1];
                r_neg_im <= ni[SUMW-1];
                r_q_re   <= nr[SUMW-1] ? SUMW'(-nr) : nr;
                r_q_im   <= ni[SUMW-1] ? SUMW'(-ni) : ni;
                r_rm_re  <= '0;
                r_rm_im  <= '0;
                r_cnt    <= '0;
            end
            vswa_pkg::t_st_div: begin
                if (r_cnt != QW'(SUMW)) begin
                    r_cnt   <= r_cnt + QW'(1);
                    r_rm_re <= tr_re[SUMW] ? pr_re[SUMW-1:0] : tr_re[SUMW-1:0];
                    r_rm_im <= tr_im[SUMW] ? pr_im[SUMW-1:0] : tr_im[SUMW-1:0];
                    r_q_re  <= {r_q_re[SUMW-2:0], ~tr_re[SUMW]};
                    r_q_im  <= {r_q_im[SUMW-2:0], ~tr_im[SUMW]};
                end
            end
            vswa_pkg::t_st_out: begin
                if (load_out) begin
                    r_out <= {SAMPLE_BITS'(r_neg_re ? -r_q_re : r_q_re),
                              SAMPLE_BITS'(r_neg_im ? -r_q_im : r_q_im), r_last};
                end
            end
            default: ;
        endcase
    end
endmodule

@@ rtl/core/vswa_checker.sv @@
// vswa_checker: port level checks for the averager, bound to the top level
// depends on vector_sliding_window_average, the bind target
module vswa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid, in_ready, out_valid, out_ready
);
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({in_ready, out_valid})) else $error("handshake unknown");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second word taken too early");
endmodule

bind vector_sliding_window_average vswa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready));
